// ===== rtl/gfa_pkg.sv =====
// shared types and constants of the gravity force accumulator
package gfa_pkg;

  localparam int DN_W       = 30;  // width of a normalized axis distance
  localparam int NORM_LO    = 29;  // normalized max distance lies in [2^29, 2^30)
  localparam int NORM_HI    = 30;
  localparam int ROOT_STEPS = 32;  // square root, one result bit per step
  localparam int DIV_STEPS  = 63;  // 2^62 / rn, one quotient bit per step
  localparam int CNT_W      = 6;
  localparam int ROOT_W     = 31;  // floor(sqrt(r2)) < 2^31
  localparam int QUO_W      = 34;  // 2^62 / rn <= 2^33

  localparam logic [1:0] REG_TARGET_X = 2'd0;
  localparam logic [1:0] REG_TARGET_Y = 2'd1;
  localparam logic [1:0] REG_TARGET_Z = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_NORM, S_SQ, S_ROOT, S_DIV, S_M1, S_M2, S_M3,
    S_QMUL, S_ACC, S_DONE, S_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_NORM, OP_SQ, OP_ROOT, OP_DIV, OP_M1, OP_M2, OP_M3,
    OP_QMUL, OP_ACC, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
    logic       first;
  } cmd_t;

  typedef struct packed {
    logic skip;      // self source or zero distance
    logic norm_hi;   // max distance at or above 2^30
    logic norm_lo;   // max distance below 2^29
    logic last;
    logic out_busy;  // result register full and stalled
  } status_t;

endpackage

// ===== rtl/gravity_force_accumulator_unit.sv =====
// top level of the direct-sum gravity force accumulator
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------------
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data (target x, y, z)
//  in      | in        | in_valid/in_stall  | mass, x, y, z, is_target, last_source
//  out     | out       | out_valid/stall    | accel_x, accel_y, accel_z, overflow
//
// one source goes through a load, a normalize check that shifts one place at a time
// (up to 29 left or 2 right), three squares on the shared multiplier, 32 square
// root steps, 63 divider steps, three multiplies, a multiply and accumulate per axis
// and a done state; the divider and root steps make up most of it.
// a self or coincident source goes from the normalize check to done; emit follows done if last.
// synchronous active-low reset clears the target registers, sums and flags.
// the result register lets the next source start while a result is stalled;
// only a second result waits for it to drain.
module gravity_force_accumulator_unit import gfa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes, always ready
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  // source transactions
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_source_mass,
  input  logic signed [COORD_WIDTH-1:0] in_source_x,
  input  logic signed [COORD_WIDTH-1:0] in_source_y,
  input  logic signed [COORD_WIDTH-1:0] in_source_z,
  input  logic                          in_is_target,
  input  logic                          in_last_source,
  // result transactions
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [63:0]            out_accel_x,
  output logic signed [63:0]            out_accel_y,
  output logic signed [63:0]            out_accel_z,
  output logic                          out_overflow
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  // sequencer: owns the input handshake and the step counters
  gfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: target registers, shared multiplier, root, divider, accumulators
  gfa_datapath #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_source_mass (in_source_mass),
    .in_source_x    (in_source_x),
    .in_source_y    (in_source_y),
    .in_source_z    (in_source_z),
    .in_is_target   (in_is_target),
    .in_last_source (in_last_source),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_accel_x    (out_accel_x),
    .out_accel_y    (out_accel_y),
    .out_accel_z    (out_accel_z),
    .out_overflow   (out_overflow),
    .cmd            (cmd),
    .status         (status)
  );

endmodule

// ===== rtl/gfa_ctrl.sv =====
// sequencer of the force datapath
module gfa_ctrl import gfa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [1:0]         axis_r, axis_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      axis_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      axis_r  <= axis_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    axis_nxt  = axis_r;
    cmd.op    = OP_NONE;
    cmd.axis  = axis_r;
    cmd.first = (cnt_r == '0);
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (status.skip) begin
          state_nxt = S_DONE;
        end else if (status.norm_hi || status.norm_lo) begin
          cmd.op = OP_NORM;
        end else begin
          state_nxt = S_SQ;
          axis_nxt  = '0;
        end
      end
      S_SQ: begin
        cmd.op = OP_SQ;
        if (axis_r == 2'd2) begin
          state_nxt = S_ROOT;
          cnt_nxt   = '0;
        end else begin
          axis_nxt = axis_r + 2'd1;
        end
      end
      S_ROOT: begin
        cmd.op = OP_ROOT;
        if (cnt_r == CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_M1;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = S_M3;
      end
      S_M3: begin
        cmd.op    = OP_M3;
        state_nxt = S_QMUL;
        axis_nxt  = '0;
      end
      S_QMUL: begin
        cmd.op    = OP_QMUL;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op = OP_ACC;
        if (axis_r == 2'd2) begin
          state_nxt = S_DONE;
        end else begin
          axis_nxt  = axis_r + 2'd1;
          state_nxt = S_QMUL;
        end
      end
      S_DONE: begin
        state_nxt = status.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  a_root_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT && cnt_r == CNT_W'(ROOT_STEPS - 1)) |=> state_r == S_DIV)
    else $error("square root did not hand over to the divider");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !status.out_busy) |=> state_r == S_IDLE)
    else $error("emit stuck with free result register");

  a_sq_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQ) |-> (!status.norm_hi && !status.norm_lo && !status.skip))
    else $error("squares taken on unnormalized distances");

endmodule

// ===== rtl/gfa_datapath.sv =====
// registers and arithmetic of the force datapath
module gfa_datapath import gfa_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  input  logic [1:0]                    cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [31:0]                   in_source_mass,
  input  logic signed [COORD_WIDTH-1:0] in_source_x,
  input  logic signed [COORD_WIDTH-1:0] in_source_y,
  input  logic signed [COORD_WIDTH-1:0] in_source_z,
  input  logic                          in_is_target,
  input  logic                          in_last_source,
  input  logic                          out_stall,
  output logic                          out_valid,
  output logic signed [63:0]            out_accel_x,
  output logic signed [63:0]            out_accel_y,
  output logic signed [63:0]            out_accel_z,
  output logic                          out_overflow,
  input  cmd_t                          cmd,
  output status_t                       status
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int MW = (DW > 31) ? DW : 31;

  logic signed [COORD_WIDTH-1:0] tgt_r [0:2];
  logic [MW-1:0]      mag_r [0:2];
  logic [2:0]         neg_r;
  logic [31:0]        mass_r;
  logic               self_r, last_r;
  logic signed [7:0]  s_r;
  logic [63:0]        r2_r, res_r, bit_r;
  logic [31:0]        rem_r;
  logic [QUO_W-1:0]   quo_r;
  logic [31:0]        i2_r, i3_r, p_r;
  logic [63:0]        q_r;
  logic signed [63:0] sum_r [0:2];
  logic               sat_r;
  logic               out_valid_r, ovf_out_r;
  logic signed [63:0] ax_r, ay_r, az_r;

  logic signed [COORD_WIDTH-1:0] src [0:2];
  logic [MW-1:0]      dmax, m01;
  logic [31:0]        mul_a, mul_b, i1;
  logic [63:0]        prod, rsum;
  logic [32:0]        rem_sh;
  logic [ROOT_W-1:0]  rn;
  logic signed [7:0]  e;
  logic [63:0]        q_sh, limit;
  logic               q_sat;
  logic signed [63:0] c;
  logic signed [64:0] acc_sum;

  assign src[0] = in_source_x;
  assign src[1] = in_source_y;
  assign src[2] = in_source_z;

  assign m01  = (mag_r[0] > mag_r[1]) ? mag_r[0] : mag_r[1];
  assign dmax = (m01 > mag_r[2]) ? m01 : mag_r[2];

  assign status.skip     = self_r || (dmax == '0);
  assign status.norm_hi  = dmax >= (MW'(1) << NORM_HI);
  assign status.norm_lo  = dmax < (MW'(1) << NORM_LO);
  assign status.last     = last_r;
  assign status.out_busy = out_valid_r && out_stall;

  assign i1 = quo_r[33:2];
  assign rn = res_r[ROOT_W-1:0];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_SQ: begin
        mul_a = 32'(mag_r[cmd.axis][DN_W-1:0]);
        mul_b = 32'(mag_r[cmd.axis][DN_W-1:0]);
      end
      OP_M1: begin
        mul_a = i1;
        mul_b = i1;
      end
      OP_M2: begin
        mul_a = i2_r;
        mul_b = i1;
      end
      OP_M3: begin
        mul_a = mass_r;
        mul_b = i3_r;
      end
      OP_QMUL: begin
        mul_a = p_r;
        mul_b = 32'(mag_r[cmd.axis][DN_W-1:0]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  assign prod   = 64'(mul_a) * 64'(mul_b);
  assign rsum   = res_r + bit_r;
  assign rem_sh = {rem_r, cmd.first};

  // scale the product by 2^e, e = -38 - 2s
  always_comb begin
    e     = -8'sd38 - (s_r <<< 1);
    limit = 64'h7fff_ffff_ffff_ffff >> e[5:0];
    q_sat = 1'b0;
    if (e >= 0) begin
      if (q_r > limit) begin
        q_sh  = 64'h7fff_ffff_ffff_ffff;
        q_sat = 1'b1;
      end else begin
        q_sh = q_r << e[5:0];
      end
    end else begin
      q_sh = (-e >= 8'sd64) ? 64'd0 : (q_r >> 6'(-e));
    end
    c       = neg_r[cmd.axis] ? -$signed(q_sh) : $signed(q_sh);
    acc_sum = {sum_r[cmd.axis][63], sum_r[cmd.axis]} + {c[63], c};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r[0]    <= '0;
      tgt_r[1]    <= '0;
      tgt_r[2]    <= '0;
      sum_r[0]    <= '0;
      sum_r[1]    <= '0;
      sum_r[2]    <= '0;
      sat_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_TARGET_X: tgt_r[0] <= COORD_WIDTH'(cfg_data);
          REG_TARGET_Y: tgt_r[1] <= COORD_WIDTH'(cfg_data);
          REG_TARGET_Z: tgt_r[2] <= COORD_WIDTH'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.op == OP_EMIT) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
      case (cmd.op)
        OP_ACC: begin
          if (acc_sum[64] != acc_sum[63]) begin
            sum_r[cmd.axis] <= acc_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            sat_r           <= 1'b1;
          end else begin
            sum_r[cmd.axis] <= acc_sum[63:0];
            if (q_sat) sat_r <= 1'b1;
          end
        end
        OP_EMIT: begin
          sum_r[0]    <= '0;
          sum_r[1]    <= '0;
          sum_r[2]    <= '0;
          sat_r       <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        for (int k = 0; k < 3; k++) begin
          logic signed [DW-1:0] d;
          d = $signed({src[k][COORD_WIDTH-1], src[k]}) -
              $signed({tgt_r[k][COORD_WIDTH-1], tgt_r[k]});
          neg_r[k] <= d[DW-1];
          mag_r[k] <= MW'(d[DW-1] ? DW'(-d) : DW'(d));
        end
        mass_r <= in_source_mass;
        self_r <= in_is_target;
        last_r <= in_last_source;
        s_r    <= '0;
        r2_r   <= '0;
        res_r  <= '0;
        bit_r  <= 64'd1 << 62;
        rem_r  <= '0;
        quo_r  <= '0;
      end
      OP_NORM: begin
        for (int k = 0; k < 3; k++) begin
          mag_r[k] <= status.norm_hi ? (mag_r[k] >> 1) : (mag_r[k] << 1);
        end
        s_r <= status.norm_hi ? s_r + 8'sd1 : s_r - 8'sd1;
      end
      OP_SQ: r2_r <= r2_r + prod;
      OP_ROOT: begin
        if (r2_r >= rsum) begin
          r2_r  <= r2_r - rsum;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV: begin
        if (rem_sh >= 33'(rn)) begin
          rem_r <= 32'(rem_sh - 33'(rn));
          quo_r <= {quo_r[QUO_W-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[31:0];
          quo_r <= {quo_r[QUO_W-2:0], 1'b0};
        end
      end
      OP_M1: i2_r <= prod[62:31];
      OP_M2: i3_r <= prod[62:31];
      OP_M3: p_r  <= prod[63:32];
      OP_QMUL: q_r <= prod;
      OP_EMIT: begin
        ax_r      <= sum_r[0];
        ay_r      <= sum_r[1];
        az_r      <= sum_r[2];
        ovf_out_r <= sat_r;
      end
      default: ;
    endcase
  end

  assign out_valid    = out_valid_r;
  assign out_accel_x  = ax_r;
  assign out_accel_y  = ay_r;
  assign out_accel_z  = az_r;
  assign out_overflow = ovf_out_r;

endmodule

// ===== tb/gfa_checker.sv =====
// checker for the gravity force accumulator: predicts results and compares them
`timescale 1ns / 100ps
module gfa_checker import gfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        in_source_mass,
  input  logic [31:0]        in_source_x,
  input  logic [31:0]        in_source_y,
  input  logic [31:0]        in_source_z,
  input  logic               in_is_target,
  input  logic               in_last_source,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [63:0] out_accel_x,
  input  logic signed [63:0] out_accel_y,
  input  logic signed [63:0] out_accel_z,
  input  logic               out_overflow,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  typedef struct packed {
    logic signed [63:0] ax;
    logic signed [63:0] ay;
    logic signed [63:0] az;
    logic               ovf;
  } accel_t;

  localparam logic signed [63:0] S64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  logic [31:0]        tgt [3];
  logic signed [63:0] acc [3];
  logic               sticky;
  accel_t             accel_q[$];

  assign pending_count = accel_q.size();

  function automatic logic [63:0] isqrt(input logic [63:0] n);
    logic [63:0] res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= res + bt) begin
        n = n - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  task automatic add_to_sum(input int ax, input logic signed [63:0] b);
    logic signed [64:0] wide;
    wide = 65'(acc[ax]) + 65'(b);
    if (wide > 65'(S64_MAX)) begin
      acc[ax] = S64_MAX;
      sticky = 1'b1;
    end else if (wide < 65'(S64_MIN)) begin
      acc[ax] = S64_MIN;
      sticky = 1'b1;
    end else begin
      acc[ax] = wide[63:0];
    end
  endtask

  // one source's pull on the target, folded into the sums
  task automatic add_pull(input logic [31:0] mass, input logic [31:0] px,
                          input logic [31:0] py, input logic [31:0] pz);
    logic [31:0] pos [3];
    logic signed [63:0] d;
    logic [63:0] mag [3], dn [3], dmax, r2, rn, inv, i1, i2, i3, p, q;
    logic neg [3];
    int s, k, e;
    pos[0] = px; pos[1] = py; pos[2] = pz;
    dmax = 0;
    for (int i = 0; i < 3; i++) begin
      d = 64'($signed(pos[i])) - 64'($signed(tgt[i]));
      neg[i] = d < 0;
      mag[i] = neg[i] ? 64'(-d) : 64'(d);
      if (mag[i] > dmax) dmax = mag[i];
    end
    if (dmax == 0) return;  // coincident source
    s = 0;
    if (dmax >= (64'd1 << NORM_HI)) begin
      while ((dmax >> s) >= (64'd1 << NORM_HI)) s++;
      for (int i = 0; i < 3; i++) dn[i] = mag[i] >> s;
    end else begin
      k = 0;
      while ((dmax << k) < (64'd1 << NORM_LO)) k++;
      for (int i = 0; i < 3; i++) dn[i] = mag[i] << k;
      s = -k;
    end
    r2 = dn[0] * dn[0] + dn[1] * dn[1] + dn[2] * dn[2];
    rn = isqrt(r2);
    if (rn == 0) return;
    inv = (64'd1 << 62) / rn;
    i1 = inv >> 2;
    i2 = (i1 * i1) >> 31;
    i3 = (i2 * i1) >> 31;
    p = (64'(mass) * i3) >> 32;
    e = -38 - 2 * s;
    for (int i = 0; i < 3; i++) begin
      q = p * dn[i];
      if (e >= 0) begin
        if (q > (64'(S64_MAX) >> e)) begin
          q = 64'(S64_MAX);
          sticky = 1'b1;
        end else begin
          q = q << e;
        end
      end else begin
        q = (-e >= 64) ? 64'd0 : (q >> (-e));
      end
      add_to_sum(i, neg[i] ? -$signed(q) : $signed(q));
    end
  endtask

  always @(posedge clk) begin
    accel_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        tgt[i] = '0;
        acc[i] = '0;
      end
      sticky = 1'b0;
      fail_count = 0;
      result_count = 0;
      accel_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET_X: tgt[0] = cfg_data;
          REG_TARGET_Y: tgt[1] = cfg_data;
          REG_TARGET_Z: tgt[2] = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        if (!in_is_target)
          add_pull(in_source_mass, in_source_x, in_source_y, in_source_z);
        if (in_last_source) begin
          accel_q.push_back('{acc[0], acc[1], acc[2], sticky});
          for (int i = 0; i < 3; i++) acc[i] = '0;
          sticky = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_accel_x, out_accel_y, out_accel_z, out_overflow};
        result_count++;
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected result %h %h %h ovf %b", $time,
                   got.ax, got.ay, got.az, got.ovf);
          fail_count++;
        end else begin
          want = accel_q.pop_front();
          if (got.ax !== want.ax) begin
            $display("%0t: accel_x expected %h actual %h", $time, want.ax, got.ax);
            fail_count++;
          end
          if (got.ay !== want.ay) begin
            $display("%0t: accel_y expected %h actual %h", $time, want.ay, got.ay);
            fail_count++;
          end
          if (got.az !== want.az) begin
            $display("%0t: accel_z expected %h actual %h", $time, want.az, got.az);
            fail_count++;
          end
          if (got.ovf !== want.ovf) begin
            $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// stimulus and verdict for the gravity force accumulator
`timescale 1ns / 100ps
module tb;
  import gfa_pkg::*;

  localparam int WATCHDOG = 20000;  // idle cycles before giving up
  localparam int DRAIN    = 300;    // wait after the last result before a register write

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = REG_TARGET_X;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [31:0]        in_source_mass = '0;
  logic [31:0]        in_source_x = '0;
  logic [31:0]        in_source_y = '0;
  logic [31:0]        in_source_z = '0;
  logic               in_is_target = 1'b0;
  logic               in_last_source = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [63:0] out_accel_x, out_accel_y, out_accel_z;
  logic               out_overflow;
  int                 fail_count, pending_count, result_count;
  int                 idle_cycles = 0;
  int                 sources_sent = 0;

  always #4 clk = ~clk;

  gravity_force_accumulator_unit dut (.*);

  gfa_checker chk (.*);

  // watchdog: any accepted transaction resets the idle count
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired at %0t", $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 150);
  endfunction

  // receiver stalls at random, with stretches of no stall
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b1;
    else if ($urandom_range(0, 99) < 30) out_stall <= ($urandom_range(0, 2) == 0);
    else out_stall <= 1'b0;
  end

  // valid stays high after the write; the next source transaction drops it
  task automatic write_target(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // valid stays high after acceptance so that sources can follow back to back
  task automatic send_source(input logic [31:0] m, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z,
                             input logic self_flag, input logic last_flag);
    int g;
    cfg_valid <= 1'b0;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_source_mass <= m;
    in_source_x    <= x;
    in_source_y    <= y;
    in_source_z    <= z;
    in_is_target   <= self_flag;
    in_last_source <= last_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sources_sent++;
  endtask

  // wait for every result, then let the datapath settle before a register write
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // random position: near the target, far away, or fully random bits
  function automatic logic [31:0] rand_pos(input logic [31:0] center);
    case ($urandom_range(0, 3))
      0: return center + 32'($signed($urandom_range(0, 2000)) - 1000);
      1: return center + 32'($signed($urandom_range(0, 32'h00ff_ffff)) - 32'sh0080_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_mass();
    case ($urandom_range(0, 5))
      0: return 32'hffff_ffff;
      1: return 32'd0;
      2: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic [31:0] t [3];
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: target at origin after reset
    send_source(32'h8000_0000, 32'h0100_0000, 0, 0, 1'b0, 1'b1);
    send_source(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1);
    send_source(32'hffff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1);
    // tiny distance with full mass saturates
    send_source(32'hffff_ffff, 32'd1, 0, 0, 1'b0, 1'b0);
    send_source(32'hffff_ffff, 32'd1, 32'd1, 0, 1'b0, 1'b1);
    send_source(32'hffff_ffff, 32'hffff_ffff, 0, 0, 1'b0, 1'b1);
    // self source, coincident source and zero mass
    send_source(32'hffff_ffff, 32'h0200_0000, 0, 0, 1'b1, 1'b1);
    send_source(32'h1234_5678, 0, 0, 0, 1'b0, 1'b1);
    send_source(32'd0, 32'h0300_0000, 32'h0100_0000, 0, 1'b0, 1'b1);
    // several sources without last, then a last
    send_source(32'h4000_0000, 32'h0100_0000, 0, 0, 1'b0, 1'b0);
    send_source(32'h4000_0000, 0, 32'hff00_0000, 0, 1'b0, 1'b0);
    send_source(32'h4000_0000, 0, 0, 32'h0080_0000, 1'b1, 1'b0);
    send_source(32'h4000_0000, 0, 0, 32'h0080_0000, 1'b0, 1'b1);
    settle();

    // extreme target corner
    write_target(REG_TARGET_X, 32'h7fff_ffff);
    write_target(REG_TARGET_Y, 32'h8000_0000);
    write_target(REG_TARGET_Z, 32'h7fff_ffff);
    send_source(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1'b0, 1'b1);
    send_source(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0, 1'b1);
    send_source(32'h0000_0001, 32'h7fff_fffe, 32'h8000_0001, 32'h7fff_ffff, 1'b0, 1'b1);
    settle();

    // random phases: every fourth puts the target at corner 7fff_ffff, the others pick a random one
    for (int ph = 0; ph < 12; ph++) begin
      for (int i = 0; i < 3; i++)
        t[i] = (ph % 4 == 0) ? 32'(ph[0] ? 32'h8000_0000 : 32'h7fff_ffff) : $urandom;
      write_target(REG_TARGET_X, t[0]);
      write_target(REG_TARGET_Y, t[1]);
      write_target(REG_TARGET_Z, t[2]);
      for (int j = 0; j < 110; j++) begin
        n = $urandom_range(0, 99);
        if (n < 5)
          send_source(rand_mass(), t[0], t[1], t[2], 1'($urandom_range(0, 1)),
                      $urandom_range(0, 3) == 0);
        else
          send_source(rand_mass(), rand_pos(t[0]), rand_pos(t[1]), rand_pos(t[2]),
                      $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
      end
      send_source(rand_mass(), rand_pos(t[0]), rand_pos(t[1]), rand_pos(t[2]), 1'b0, 1'b1);
      settle();
    end

    $display("sent %0d sources over 14 target settings, checked %0d results",
             sources_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
